// ===== rtl/core/dtu_pkg.sv =====
// Shared types and constants for the DVB text to UTF-8 decoder.
// No dependencies; imported by dtu_exec and dvb_text_to_utf8_decoder.
package dtu_pkg;

  localparam int unsigned DEF_MAX_OUTPUT_BYTES = 4095;
  localparam int unsigned DEF_TABLE_SLOTS      = 16;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CAP_W    = 12;
  localparam int unsigned CS_W     = 4;
  localparam int unsigned ENTRY_W  = 7;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SET_SPAN = 128;
  localparam int unsigned MAX_RES  = 4;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned M_TUSER_W = 2;

  localparam logic [CS_W-1:0] CS_UTF8 = 4'd14;
  localparam logic [CS_W-1:0] CS_6937 = 4'd15;

  localparam logic [BYTE_W-1:0] SEL_ESC  = 8'h10;
  localparam logic [BYTE_W-1:0] SEL_UTF8 = 8'h15;

  typedef enum logic [1:0] {
    ST_TEXT   = 2'd0,
    ST_DONE   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_BODY = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_SEL  = 4'b0100,
    PH_BAD  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              lastb;
    logic [CAP_W-1:0]  cap;
    logic [CS_W-1:0]   cs_new;
    logic              cs_bad;
    logic              lookup_ok;
    logic [WORD_W-1:0] word;
  } dtu_item_t;

endpackage

// ===== rtl/core/dtu_exec.sv =====
// String decode engine: framing, charset, room tracking, UTF-8 encoding
// and the result buffer. Depends on dtu_pkg.
module dtu_exec import dtu_pkg::*; #(
  parameter int unsigned MAX_OUTPUT_BYTES = DEF_MAX_OUTPUT_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  dtu_item_t            item_i,
  output logic                 item_ready_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_byte
  output logic [M_TUSER_W-1:0] m_axis_tuser,  // status
  output logic                 m_axis_tlast   // last
);

  logic [CS_W-1:0]   cs_q, cs_d;
  phase_e            ph_q, ph_d;
  logic [CAP_W-1:0]  room_q, room_d;
  logic              dead_q, dead_d;

  logic [BYTE_W-1:0] em_byte_q [MAX_RES];
  status_e           em_stat_q [MAX_RES];
  logic [2:0]        em_cnt_q;

  logic [BYTE_W-1:0] res_byte [MAX_RES];
  status_e           res_stat [MAX_RES];
  logic [2:0]        n;

  logic [BYTE_W-1:0] c;
  logic [CAP_W-1:0]  cap_lim;
  logic [CS_W-1:0]   cs_app;
  logic [CS_W-1:0]   cs_b;
  phase_e            ph_b;
  logic [CAP_W-1:0]  room_b;
  logic              b_rej;
  logic [1:0]        b_n;
  logic [BYTE_W-1:0] b_byte [3];
  logic [1:0]        b_len;
  logic [WORD_W-1:0] uc;

  logic emit_free, take, pop;

  assign emit_free    = (em_cnt_q == 3'd0) || ((em_cnt_q == 3'd1) && m_axis_tready);
  assign item_ready_o = emit_free;
  assign take         = item_valid_i && emit_free;
  assign pop          = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = (em_cnt_q != 3'd0);
  assign m_axis_tdata  = em_byte_q[0];
  assign m_axis_tuser  = em_stat_q[0];
  assign m_axis_tlast  = (em_cnt_q == 3'd1);

  always_comb begin
    c      = item_i.data;
    uc     = item_i.word;
    cs_app = item_i.cs_bad ? '0 : item_i.cs_new;

    if (32'(item_i.cap) > MAX_OUTPUT_BYTES) begin
      cap_lim = CAP_W'(MAX_OUTPUT_BYTES);
    end else begin
      cap_lim = item_i.cap;
    end

    // operands for one body byte
    cs_b   = item_i.first ? cs_app : cs_q;
    ph_b   = item_i.first ? (item_i.cs_bad ? PH_BAD : PH_BODY) : ph_q;
    room_b = item_i.first ? cap_lim : room_q;

    b_rej  = 1'b0;
    b_n    = 2'd0;
    b_len  = 2'd1;
    for (int i = 0; i < 3; i++) begin
      b_byte[i] = '0;
    end

    if (uc[15:11] != 5'd0) begin
      b_len = 2'd3;
    end else if (uc[10:7] != 4'd0) begin
      b_len = 2'd2;
    end

    priority if (ph_b == PH_BAD || room_b == '0) begin
      b_rej = 1'b1;
    end else if (cs_b == CS_UTF8 || !c[7]) begin
      b_n       = 2'd1;
      b_byte[0] = c;
    end else if (c <= 8'h9f) begin
      b_n       = 2'd1;
      b_byte[0] = 8'h20;
    end else if (uc == '0) begin
      b_n = 2'd0;
    end else if (room_b < CAP_W'(b_len)) begin
      b_rej = 1'b1;
    end else begin
      b_n = b_len;
      unique case (b_len)
        2'd1: b_byte[0] = uc[7:0];
        2'd2: begin
          b_byte[0] = {3'b110, uc[10:6]};
          b_byte[1] = {2'b10, uc[5:0]};
        end
        default: begin
          b_byte[0] = {4'b1110, uc[15:12]};
          b_byte[1] = {2'b10, uc[11:6]};
          b_byte[2] = {2'b10, uc[5:0]};
        end
      endcase
    end

    cs_d   = cs_q;
    ph_d   = ph_q;
    room_d = room_q;
    dead_d = dead_q;
    n      = 3'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_byte[i] = '0;
      res_stat[i] = ST_TEXT;
    end

    if (item_i.first) begin
      room_d = cap_lim;
      dead_d = 1'b0;
      ph_d   = PH_BODY;
      priority if (c >= 8'h20) begin
        cs_d = cs_b;
        ph_d = ph_b;
        if (b_rej) begin
          dead_d = 1'b1;
          ph_d   = PH_BODY;
          res_stat[0] = ST_REJECT;
          n = 3'd1;
        end else begin
          room_d = room_b - CAP_W'(b_n);
          for (int i = 0; i < 3; i++) begin
            res_byte[i] = b_byte[i];
          end
          n = {1'b0, b_n};
        end
      end else if (c == SEL_ESC) begin
        ph_d = PH_ESC;
        if (item_i.lastb) begin
          dead_d = 1'b1;
          ph_d   = PH_BODY;
          res_stat[0] = ST_REJECT;
          n = 3'd1;
        end
      end else if (c == SEL_UTF8) begin
        cs_d = CS_UTF8;
      end else if (c >= 8'h01 && c <= 8'h0b) begin
        cs_d = cs_app;
        ph_d = item_i.cs_bad ? PH_BAD : PH_BODY;
      end else begin
        dead_d = 1'b1;
        ph_d   = PH_BODY;
        res_stat[0] = ST_REJECT;
        n = 3'd1;
      end
    end else if (dead_q) begin
      n = 3'd0;
    end else if (ph_q == PH_ESC) begin
      if (c != 8'h00 || item_i.lastb) begin
        dead_d = 1'b1;
        ph_d   = PH_BODY;
        res_stat[0] = ST_REJECT;
        n = 3'd1;
      end else begin
        ph_d = PH_SEL;
      end
    end else if (ph_q == PH_SEL) begin
      if (c == 8'h00 || c > 8'h0f) begin
        dead_d = 1'b1;
        ph_d   = PH_BODY;
        res_stat[0] = ST_REJECT;
        n = 3'd1;
      end else begin
        cs_d = cs_app;
        ph_d = item_i.cs_bad ? PH_BAD : PH_BODY;
      end
    end else begin
      if (b_rej) begin
        dead_d = 1'b1;
        ph_d   = PH_BODY;
        res_stat[0] = ST_REJECT;
        n = 3'd1;
      end else begin
        room_d = room_b - CAP_W'(b_n);
        for (int i = 0; i < 3; i++) begin
          res_byte[i] = b_byte[i];
        end
        n = {1'b0, b_n};
      end
    end

    // end-of-string mark
    if (!dead_d && item_i.lastb) begin
      res_byte[n[1:0]] = '0;
      res_stat[n[1:0]] = ST_DONE;
      n      = n + 3'd1;
      dead_d = 1'b1;
      ph_d   = PH_BODY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q     <= '0;
      ph_q     <= PH_BODY;
      room_q   <= '0;
      dead_q   <= 1'b1;
      em_cnt_q <= 3'd0;
    end else begin
      if (take) begin
        cs_q   <= cs_d;
        ph_q   <= ph_d;
        room_q <= room_d;
        dead_q <= dead_d;
      end
      if (take && n != 3'd0) begin
        em_cnt_q <= n;
      end else if (pop) begin
        em_cnt_q <= em_cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && n != 3'd0) begin
      em_byte_q <= res_byte;
      em_stat_q <= res_stat;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        em_byte_q[i] <= em_byte_q[i+1];
        em_stat_q[i] <= em_stat_q[i+1];
      end
    end
  end

endmodule

// ===== rtl/core/dvb_text_to_utf8_decoder.sv =====
// DVB SI text to UTF-8 decoder, top level: input stage, code table memory,
// charset tracking for lookups. Depends on dtu_pkg and dtu_exec.
// An input passes the input stage register and then the result buffer before its first result.
// Throughput: one input per cycle while each yields at most one result and m_axis_tready
// is high; an input with k results (k <= 4) holds the result buffer until its last is taken.
// The code table is one RAM port per cycle, read at the input transfer.
// Reset clears control state only; table contents are undefined until written.
module dvb_text_to_utf8_decoder import dtu_pkg::*; #(
  parameter int unsigned MAX_OUTPUT_BYTES = DEF_MAX_OUTPUT_BYTES,
  parameter int unsigned TABLE_SLOTS      = DEF_TABLE_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CS_W-1:0]      cfg_data_i,     // default_charset
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // table_slot, table_entry, table_word, data_byte, out_capacity, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // req_type, first_byte
  input  logic                 s_axis_tlast,   // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // out_byte
  output logic [M_TUSER_W-1:0] m_axis_tuser,   // status
  output logic                 m_axis_tlast    // last
);

  localparam int unsigned Depth = TABLE_SLOTS * SET_SPAN;
  localparam int unsigned AddrW = $clog2(Depth);

  function automatic logic [CS_W:0] iso_set(input logic [CS_W:0] n);
    logic [CS_W:0] r;
    if (n >= 5'd1 && n <= 5'd11) begin
      r = n - 5'd1;
    end else if (n >= 5'd13 && n <= 5'd15) begin
      r = n - 5'd2;
    end else begin
      r = 5'd16;
    end
    return r;
  endfunction

  logic [CS_W-1:0]    dflt_q;
  logic [CS_W-1:0]    fr_cs_q, fr_cs_d;
  phase_e             fr_ph_q, fr_ph_d;
  logic               s1_valid_q;
  dtu_item_t          s1_q, s1_d, ex_item;
  logic [WORD_W-1:0]  rd_q;
  logic [WORD_W-1:0]  mem [Depth];

  logic [CS_W-1:0]    slot;
  logic [ENTRY_W-1:0] entry;
  logic [WORD_W-1:0]  word;
  logic [BYTE_W-1:0]  c;
  logic [CAP_W-1:0]   cap;
  logic               req_str, first;

  logic [CS_W:0]      dflt_cs, sel_cs;
  logic [CS_W-1:0]    cs_app, addr_cs;
  logic               lookup_ok;
  logic [ENTRY_W-1:0] rd_entry;
  logic               accept, str_acc, wr_en, rd_en, ex_ready;

  assign slot    = s_axis_tdata[3:0];
  assign entry   = s_axis_tdata[10:4];
  assign word    = s_axis_tdata[26:11];
  assign c       = s_axis_tdata[34:27];
  assign cap     = s_axis_tdata[46:35];
  assign req_str = s_axis_tuser[0];
  assign first   = s_axis_tuser[1];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !s1_valid_q || ex_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign str_acc       = accept && req_str;
  assign wr_en         = accept && !req_str && (32'(slot) < TABLE_SLOTS);

  // charset seen by this byte, tracked ahead of the decode stage
  always_comb begin
    dflt_cs = (dflt_q == '0) ? {1'b0, CS_6937} : iso_set({1'b0, dflt_q});
    if (first) begin
      if (c >= 8'h01 && c <= 8'h0b) begin
        sel_cs = iso_set(c[CS_W:0] + 5'd4);
      end else if (c == SEL_UTF8) begin
        sel_cs = {1'b0, CS_UTF8};
      end else begin
        sel_cs = dflt_cs;
      end
    end else begin
      sel_cs = iso_set(c[CS_W:0]);
    end
    cs_app    = sel_cs[CS_W] ? '0 : sel_cs[CS_W-1:0];
    addr_cs   = first ? cs_app : fr_cs_q;
    lookup_ok = (32'(addr_cs) < TABLE_SLOTS);
    rd_entry  = c[ENTRY_W-1:0] - 7'h20;
    rd_en     = str_acc && lookup_ok;

    fr_cs_d = fr_cs_q;
    fr_ph_d = fr_ph_q;
    if (str_acc) begin
      if (first) begin
        fr_ph_d = (c == SEL_ESC) ? PH_ESC : PH_BODY;
        if ((c >= 8'h01 && c <= 8'h0b) || c == SEL_UTF8 || c >= 8'h20) begin
          fr_cs_d = cs_app;
        end
      end else if (fr_ph_q == PH_ESC) begin
        fr_ph_d = PH_SEL;
      end else if (fr_ph_q == PH_SEL) begin
        fr_cs_d = cs_app;
        fr_ph_d = PH_BODY;
      end
    end

    s1_d.data      = c;
    s1_d.first     = first;
    s1_d.lastb     = s_axis_tlast;
    s1_d.cap       = cap;
    s1_d.cs_new    = sel_cs[CS_W-1:0];
    s1_d.cs_bad    = sel_cs[CS_W];
    s1_d.lookup_ok = lookup_ok;
    s1_d.word      = '0;

    ex_item      = s1_q;
    ex_item.word = s1_q.lookup_ok ? rd_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q     <= '0;
      fr_cs_q    <= '0;
      fr_ph_q    <= PH_BODY;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dflt_q <= cfg_data_i;
      end
      fr_cs_q <= fr_cs_d;
      fr_ph_q <= fr_ph_d;
      if (s_axis_tready) begin
        s1_valid_q <= str_acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (str_acc) begin
      s1_q <= s1_d;
    end
  end

  // code table: at most one write or one read per transfer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AddrW'({slot, entry})] <= word;
    end
    if (rd_en) begin
      rd_q <= mem[AddrW'({addr_cs, rd_entry})];
    end
  end

  dtu_exec #(
    .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES)
  ) u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (s1_valid_q),
    .item_i        (ex_item),
    .item_ready_o  (ex_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
